>>> rtl/core/sss_pkg.sv
// Shared types, register codes and helpers for the streaming substring search.
// Used by every module under rtl/core; depends on nothing.
package sss_pkg;

    // Hard limits of the pattern store
    localparam int PATTERN_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int START_W       = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LO  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HI  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_CASE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_LAST = 3'd4;

    // Character constants for case folding
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // Input word: one text byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_word;

    // Output word: one search result
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] match_start;
        logic               offset_overflow;
    } t_out_word;

    // Configuration register file contents
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_hi;
        logic [CFG_DATA_W-1:0] pattern_lo;
        logic [LEN_W-1:0]      pattern_length;
        logic                  ignore_case;
        logic                  report_last;
    } t_cfg;

    // Window compare status handed to the tracker
    typedef struct packed {
        logic             bytes_eq;
        logic [LEN_W-1:0] len_eff;
    } t_win_status;

    // Fold A-Z to a-z when enabled
    function automatic logic [7:0] fold(input logic [7:0] c, input logic ignore_case);
        logic [7:0] r;
        r = c;
        if (ignore_case && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/substring_search_first_or_last.sv
// Top level of the streaming substring search, first or last match.
// Depends on sss_pkg, sss_window, sss_track and sss_out_buf.
//
// Streams a text one byte per word and searches it for a pattern of up to
// PATTERN_MAX bytes (overlapping matches, optional A-Z folding). The block
// takes one word every clock cycle while not stalled; the parallel compare of
// the whole pattern against the byte window is combinational. On the word
// marked end_of_text a result (found, start offset, overflow) is registered
// into the two-word output buffer, which lets input continue while a result
// waits; input stalls only when both result slots are full.
// Write configuration only while no text is in progress.
module substring_search_first_or_last #(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [sss_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Text input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sss_pkg::t_in_word                   i_in_word,
    // Result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sss_pkg::t_out_word                  o_out_word
);

    sss_pkg::t_cfg        r_cfg;
    sss_pkg::t_win_status win_status;
    sss_pkg::t_out_word   res_word;
    logic                 res_valid;
    logic                 accept;
    logic                 buf_full;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sss_pkg::CFG_PATTERN_LO:  r_cfg.pattern_lo     <= i_cfg_data;
                sss_pkg::CFG_PATTERN_HI:  r_cfg.pattern_hi     <= i_cfg_data;
                sss_pkg::CFG_PATTERN_LEN: r_cfg.pattern_length <= i_cfg_data[sss_pkg::LEN_W-1:0];
                sss_pkg::CFG_IGNORE_CASE: r_cfg.ignore_case    <= i_cfg_data[0];
                sss_pkg::CFG_REPORT_LAST: r_cfg.report_last    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sss_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .i_cfg    (r_cfg),
        .o_status (win_status)
    );

    sss_track #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_end_of_text (i_in_word.end_of_text),
        .i_report_last (r_cfg.report_last),
        .i_status      (win_status),
        .o_res_valid   (res_valid),
        .o_res         (res_word)
    );

    sss_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_word (res_word),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

>>> rtl/core/sss_window.sv
// Recent-byte window and parallel pattern compare for the substring search.
// Depends on sss_pkg.
module sss_window #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  sss_pkg::t_in_word     i_word,
    input  sss_pkg::t_cfg         i_cfg,
    output sss_pkg::t_win_status  o_status
);

    logic [7:0]                 r_recent [PATTERN_MAX];
    logic [7:0]                 w_win    [PATTERN_MAX];
    logic [sss_pkg::LEN_W-1:0]  len_eff;
    logic [PATTERN_MAX-1:0]     eq;
    logic [8*sss_pkg::PATTERN_BYTES-1:0] pattern;

    assign pattern = {i_cfg.pattern_hi, i_cfg.pattern_lo};

    // Clamp the length to the window depth
    always_comb begin
        if (i_cfg.pattern_length > sss_pkg::LEN_W'(PATTERN_MAX)) begin
            len_eff = sss_pkg::LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = i_cfg.pattern_length;
        end
    end

    // Window as it stands after this byte: newest in slot 0
    always_comb begin
        w_win[0] = i_word.text_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            w_win[k] = r_recent[k-1];
        end
    end

    // Compare pattern byte i against window slot len-1-i
    always_comb begin
        logic [sss_pkg::LEN_W-1:0] idx;
        logic [7:0]                sel;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            idx = len_eff - sss_pkg::LEN_W'(i) - sss_pkg::LEN_W'(1);
            sel = '0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                if (sss_pkg::LEN_W'(k) == idx) begin
                    sel = w_win[k];
                end
            end
            eq[i] = (sss_pkg::LEN_W'(i) >= len_eff) ||
                    (sss_pkg::fold(pattern[8*i +: 8], i_cfg.ignore_case) ==
                     sss_pkg::fold(sel, i_cfg.ignore_case));
        end
    end

    assign o_status.bytes_eq = (&eq) && (len_eff != '0);
    assign o_status.len_eff  = len_eff;

    // Shift in on each word, drop history at end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_recent[k] <= '0;
            end
        end else if (i_accept) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_recent[k] <= i_word.end_of_text ? 8'h00 : w_win[k];
            end
        end
    end

endmodule

>>> rtl/core/sss_track.sv
// Offset counter and first/last match tracking; forms the result word.
// Depends on sss_pkg.
module sss_track #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_end_of_text,
    input  logic                 i_report_last,
    input  sss_pkg::t_win_status i_status,
    output logic                 o_res_valid,
    output sss_pkg::t_out_word   o_res
);

    localparam int SW = (OFFSET_BITS > sss_pkg::START_W) ? OFFSET_BITS : sss_pkg::START_W;

    logic [OFFSET_BITS:0]           r_offset, n_offset;
    logic                           r_seen, n_seen;
    logic [sss_pkg::START_W-1:0]    r_saved, n_saved;
    logic                           r_ovf, n_ovf;

    logic                           beyond;
    logic [OFFSET_BITS+1:0]         here_p1;
    logic                           enough;
    logic                           hit;
    logic [OFFSET_BITS-1:0]         start_full;
    logic [SW-1:0]                  start_ext;
    logic [sss_pkg::START_W-1:0]    start_cap;

    // Position of this byte and whether a full pattern fits behind it
    assign beyond  = r_offset[OFFSET_BITS];
    assign here_p1 = {1'b0, r_offset} + (OFFSET_BITS+2)'(1);
    assign enough  = beyond || (here_p1 >= (OFFSET_BITS+2)'(i_status.len_eff));
    assign hit     = i_status.bytes_eq && enough;

    // Start offset, saturated then capped to the output width
    assign start_full = beyond ? {OFFSET_BITS{1'b1}}
                               : OFFSET_BITS'(here_p1 - (OFFSET_BITS+2)'(i_status.len_eff));
    assign start_ext  = SW'(start_full);
    assign start_cap  = (start_ext > SW'({sss_pkg::START_W{1'b1}})) ?
                        {sss_pkg::START_W{1'b1}} : start_ext[sss_pkg::START_W-1:0];

    // Update text state for this byte
    always_comb begin
        n_offset = beyond ? r_offset : here_p1[OFFSET_BITS:0];
        n_ovf    = r_ovf | beyond;
        n_seen   = r_seen;
        n_saved  = r_saved;
        if (hit && (i_report_last || !r_seen)) begin
            n_seen  = 1'b1;
            n_saved = start_cap;
        end
    end

    // Result for an end-of-text word
    assign o_res_valid           = i_accept && i_end_of_text;
    assign o_res.found           = n_seen;
    assign o_res.match_start     = n_seen ? n_saved : '0;
    assign o_res.offset_overflow = n_ovf;

    // Hold state; clear after end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_seen   <= 1'b0;
            r_saved  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_accept) begin
            if (i_end_of_text) begin
                r_offset <= '0;
                r_seen   <= 1'b0;
                r_saved  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_offset <= n_offset;
                r_seen   <= n_seen;
                r_saved  <= n_saved;
                r_ovf    <= n_ovf;
            end
        end
    end

endmodule

>>> rtl/core/sss_out_buf.sv
// Two-entry output register with skid slot for result words.
// Depends on sss_pkg.
module sss_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sss_pkg::t_out_word i_push_word,
    output logic               o_full,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sss_pkg::t_out_word o_out_word
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    sss_pkg::t_out_word r_out, n_out;
    sss_pkg::t_out_word r_skid, n_skid;
    logic               pop;

    assign pop = r_out_valid && !i_out_stall;

    // Advance skid or a new word into output, or park a new word in the skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_push_word;
            end else begin
                n_out_valid  = i_push;
                n_out        = i_push_word;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Skid slot is only ever behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word present without output word");

    // No push while the skid slot is occupied
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into full buffer");

    // Skid fills only when the output was held by a stall
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid filled while output was free");

endmodule

>>> dv/tb_substring_search_first_or_last.sv
// Self-checking testbench for the streaming substring search, first or last match.
// Depends on sss_pkg and substring_search_first_or_last; checks every result word
// against a cycle-free prediction of the search kept inside this module.
module tb_substring_search_first_or_last;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_SPAN  = 65536;
    localparam int SETTLE       = 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;

    typedef logic [7:0] t_text[$];

    // Clock, reset and block inputs, all known from time zero
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [sss_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [sss_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    sss_pkg::t_in_word               i_in_word   = '0;
    logic                            i_out_stall = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    sss_pkg::t_out_word              o_out_word;

    // Search settings as last written
    logic [63:0] pat_lo    = '0;
    logic [63:0] pat_hi    = '0;
    logic [4:0]  pat_len   = '0;
    logic        fold_on   = 1'b0;
    logic        keep_last = 1'b0;

    // Per-text search state
    logic [7:0]  win_bytes [16];
    int          txt_pos   = 0;
    logic        txt_hit   = 1'b0;
    logic [15:0] hit_start = '0;
    logic        txt_ovf   = 1'b0;

    sss_pkg::t_out_word results_due[$];
    int          err_count    = 0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          hold_req     = 0;
    int          hold_left    = 0;
    int          quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    substring_search_first_or_last u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        foreach (win_bytes[i]) win_bytes[i] = '0;
    end

    // Pattern byte i of the current settings
    function automatic logic [7:0] pat_byte(input int i);
        if (i < 8) begin
            return pat_lo[8*i +: 8];
        end
        return pat_hi[8*(i-8) +: 8];
    endfunction

    // Fold upper-case letters when case folding is on
    function automatic logic [7:0] lower_if(input logic [7:0] c);
        if (fold_on && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Randomly swap the case of a letter
    function automatic logic [7:0] case_mix(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // Advance the search by one accepted word; queue a result on end of text
    function automatic void search_step(input sss_pkg::t_in_word w);
        int                 here;
        int                 plen;
        int                 start;
        logic               beyond;
        logic               hit;
        sss_pkg::t_out_word res;
        here   = txt_pos;
        beyond = (here >= OFFSET_SPAN);
        plen   = (pat_len > 16) ? 16 : int'(pat_len);
        for (int k = 15; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = w.text_byte;
        if (beyond) begin
            txt_ovf = 1'b1;
        end else begin
            txt_pos = here + 1;
        end
        if (plen > 0 && (beyond || here + 1 >= plen)) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++) begin
                if (lower_if(pat_byte(i)) != lower_if(win_bytes[plen-1-i])) hit = 1'b0;
            end
            if (hit && (keep_last || !txt_hit)) begin
                start = beyond ? OFFSET_SPAN - 1 : here + 1 - plen;
                if (start > 65535) start = 65535;
                hit_start = start[15:0];
                txt_hit   = 1'b1;
            end
        end
        if (w.end_of_text) begin
            res.found           = txt_hit;
            res.match_start     = txt_hit ? hit_start : 16'd0;
            res.offset_overflow = txt_ovf;
            results_due.push_back(res);
            foreach (win_bytes[i]) win_bytes[i] = '0;
            txt_pos   = 0;
            txt_hit   = 1'b0;
            hit_start = '0;
            txt_ovf   = 1'b0;
        end
    endfunction

    // Offer one word, hold it until accepted, then predict
    task automatic send_word(input logic [7:0] b, input logic eot);
        sss_pkg::t_in_word w;
        w.text_byte   = b;
        w.end_of_text = eot;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        search_step(w);
    endtask

    task automatic send_text(input t_text txt);
        for (int i = 0; i < txt.size(); i++) send_word(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_str(input string s);
        t_text txt;
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        send_text(txt);
    endtask

    // Drop valid, wait for all results, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            sss_pkg::CFG_PATTERN_LO:  pat_lo    = data;
            sss_pkg::CFG_PATTERN_HI:  pat_hi    = data;
            sss_pkg::CFG_PATTERN_LEN: pat_len   = data[4:0];
            sss_pkg::CFG_IGNORE_CASE: fold_on   = data[0];
            sss_pkg::CFG_REPORT_LAST: keep_last = data[0];
            default: ;
        endcase
    endtask

    // Write all five registers; unused upper data bits carry noise
    task automatic apply_settings(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [4:0] len, input logic fold,
                                  input logic last);
        logic [63:0] d;
        write_reg(sss_pkg::CFG_PATTERN_LO, lo);
        write_reg(sss_pkg::CFG_PATTERN_HI, hi);
        d = {$urandom, $urandom};
        d[4:0] = len;
        write_reg(sss_pkg::CFG_PATTERN_LEN, d);
        d = {$urandom, $urandom};
        d[0] = fold;
        write_reg(sss_pkg::CFG_IGNORE_CASE, d);
        d = {$urandom, $urandom};
        d[0] = last;
        write_reg(sss_pkg::CFG_REPORT_LAST, d);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Zero length, extreme bytes, both modes, folding, text boundaries
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // zero-length pattern never matches
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_drained();
        // first mode: match right at text start, none across texts
        apply_settings(64'h0000_0000_0063_6261, 64'h0, 5'd3, 1'b0, 1'b0);
        send_str("abcabc");
        send_str("ab");
        send_str("c");
        wait_drained();
        // last mode with case folding on both sides
        apply_settings(64'h0000_0000_0063_4261, 64'h0, 5'd3, 1'b1, 1'b1);
        send_str("ABCAbc");
        wait_drained();
        // zero byte as an ordinary pattern byte
        apply_settings(64'h0000_0000_0000_FF00, 64'h0, 5'd2, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Random patterns and texts under three idling profiles
    task automatic test_random_texts();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  b;
        logic [4:0]  len;
        t_text       txt;
        int          sent;
        int          plen;
        int          n;
        int          pos;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 58;
                end
                1: begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 7;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int step = 0; step < 6; step++) begin
                // pick pattern: mostly a few letters in mixed case
                for (int i = 0; i < 16; i++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        b = case_mix(8'h61 + 8'($urandom_range(0, 2)));
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                    if (i < 8) lo[8*i +: 8] = b;
                    else hi[8*(i-8) +: 8] = b;
                end
                len = 5'($urandom_range(1, 6));
                case (step)
                    0: len = 5'd16;
                    1: begin
                        len = 5'($urandom_range(17, 31));
                        lo  = '1;
                        hi  = '1;
                    end
                    2: len = 5'd0;
                    3: begin
                        lo = '0;
                        hi = '0;
                    end
                    default: ;
                endcase
                apply_settings(lo, hi, len, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                plen = (pat_len > 16) ? 16 : int'(pat_len);
                sent = 0;
                while (sent < 90) begin
                    txt = {};
                    if ($urandom_range(0, 9) < 8) begin
                        // well-formed: bytes near the pattern plus whole copies
                        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
                                                        : $urandom_range(1, 20);
                        for (int j = 0; j < n; j++) begin
                            if (plen > 0 && $urandom_range(0, 9) < 6) begin
                                txt.push_back(case_mix(pat_byte($urandom_range(0, plen - 1))));
                            end else begin
                                txt.push_back(8'($urandom_range(0, 255)));
                            end
                        end
                        repeat ($urandom_range(0, 2)) begin
                            pos = $urandom_range(0, n - 1);
                            for (int j = 0; j < plen; j++) begin
                                if (pos + j < txt.size()) txt[pos+j] = case_mix(pat_byte(j));
                                else txt.push_back(case_mix(pat_byte(j)));
                            end
                        end
                    end else begin
                        // noise: short runs of arbitrary bytes
                        n = $urandom_range(1, 8);
                        for (int j = 0; j < n; j++) txt.push_back(8'($urandom_range(0, 255)));
                    end
                    send_text(txt);
                    sent += txt.size();
                end
                wait_drained();
            end
        end
    endtask

    // Hold the result side off long enough to fill the block and stall its input
    task automatic test_backpressure();
        t_text txt;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(64'h61, 64'h0, 5'd1, 1'b0, 1'b1);
        hold_req = HOLD_CYCLES;
        for (int t = 0; t < 40; t++) begin
            txt = {};
            repeat ($urandom_range(1, 3)) txt.push_back($urandom_range(0, 1) ? 8'h61 : 8'h62);
            send_text(txt);
        end
        wait_drained();
    endtask

    // Drive the result stall: long hold-off on request, else random
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        sss_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result word: expected none, actual %h",
                         $time, o_out_word);
            end else begin
                want = results_due.pop_front();
                if (o_out_word.found !== want.found) begin
                    err_count++;
                    $display("%0t: found: expected %0d actual %0d",
                             $time, want.found, o_out_word.found);
                end
                if (o_out_word.match_start !== want.match_start) begin
                    err_count++;
                    $display("%0t: match_start: expected %0d actual %0d",
                             $time, want.match_start, o_out_word.match_start);
                end
                if (o_out_word.offset_overflow !== want.offset_overflow) begin
                    err_count++;
                    $display("%0t: offset_overflow: expected %0d actual %0d",
                             $time, want.offset_overflow, o_out_word.offset_overflow);
                end
            end
        end
    end

    // Count cycles in which no word moves on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("substring_search_first_or_last test failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);
        test_directed();
        test_random_texts();
        test_backpressure();
        wait_drained();
        if (err_count == 0) begin
            $display("substring_search_first_or_last test passed");
        end else begin
            $display("substring_search_first_or_last test failed");
        end
        $finish;
    end

endmodule
